/* hw/rtl/raycast_wall_slice_projection_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the wall slice projection block
// Clock clk_i and active-low reset rst_ni are taken from the using module.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_WALL_SLICE_PROJECTION_ASSERT_SVH
`define RAYCAST_WALL_SLICE_PROJECTION_ASSERT_SVH

// prop holds at every edge out of reset
`define RCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// a implies b in the same cycle
`define RCW_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define RCW_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);

`endif

/* hw/rtl/rcw_pkg.sv */
// ----------------------------------------------------------------------------
// rcw_pkg
// Shared constants for the wall slice projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

  localparam int unsigned ScreenHeightDef = 512;

  localparam int unsigned PosW  = 24;
  localparam int unsigned DirW  = 18;
  localparam int unsigned TexWW = 11;
  localparam int unsigned LhW   = 16;
  localparam int unsigned RowW  = 9;
  localparam int unsigned TexCW = 10;

  localparam logic [PosW-1:0] DistMax   = '1;
  localparam logic [LhW-1:0]  HeightMax = '1;
  localparam logic [TexWW-1:0] TexWMax  = 11'd1024;

  typedef enum logic [1:0] {
    REG_PLAYER_X  = 2'd0,
    REG_PLAYER_Y  = 2'd1,
    REG_TEX_WIDTH = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

/* hw/rtl/rcw_div_stage.sv */
// ----------------------------------------------------------------------------
// rcw_div_stage
// A few steps of restoring unsigned division: shift in dividend bits,
// trial subtract, one quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_div_stage #(
  parameter int unsigned DW   = 18,
  parameter int unsigned QW   = 24,
  parameter int unsigned BITS = 4
) (
  input  logic [DW-1:0]   rem_i,
  input  logic [DW-1:0]   div_i,
  input  logic [BITS-1:0] bits_i,
  input  logic [QW-1:0]   q_i,
  output logic [DW-1:0]   rem_o,
  output logic [QW-1:0]   q_o
);

  always_comb begin
    logic [DW:0]   sh;
    logic [DW-1:0] r;
    logic [QW-1:0] q;
    r = rem_i;
    q = q_i;
    for (int i = BITS - 1; i >= 0; i--) begin
      sh = {r, bits_i[i]};
      q  = {q[QW-2:0], 1'b0};
      if (sh >= {1'b0, div_i}) begin
        sh   = sh - {1'b0, div_i};
        q[0] = 1'b1;
      end
      r = sh[DW-1:0];
    end
    rem_o = r;
    q_o   = q;
  end

endmodule

`default_nettype wire

/* hw/rtl/raycast_wall_slice_projection.sv */
// Throughput: one item per cycle unless the output stalls; the two dividers
// are pipelined at four quotient bits per stage (6 stages for distance, 4 for
// line height). A stall at the output freezes every stage at once.
// Reset clears the stage valid bits and sets player position 0 and
// texture width 64.
// ----------------------------------------------------------------------------
// raycast_wall_slice_projection
// Perpendicular wall distance, slice height, clamped rows and texture column
// for one ray hit per item.
// ----------------------------------------------------------------------------
`default_nettype none

module raycast_wall_slice_projection
  import rcw_pkg::*;
#(
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [PosW-1:0]        cfg_data_i,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic                   wall_side_i,
  input  logic [7:0]             cell_x_i,
  input  logic [7:0]             cell_y_i,
  input  logic signed [1:0]      step_x_i,
  input  logic signed [1:0]      step_y_i,
  input  logic signed [DirW-1:0] ray_dir_x_i,
  input  logic signed [DirW-1:0] ray_dir_y_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic [PosW-1:0]        wall_distance_o,
  output logic [LhW-1:0]         slice_height_o,
  output logic [RowW-1:0]        row_first_o,
  output logic [RowW-1:0]        row_last_o,
  output logic [TexCW-1:0]       texture_column_o
);

`include "raycast_wall_slice_projection_assert.svh"

  localparam int unsigned ShW   = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned SumW  = ((ShW > LhW - 1) ? ShW : LhW - 1) + 1;
  localparam int unsigned NSt   = 15;
  localparam int unsigned Last  = NSt - 1;
  localparam int unsigned D1Beg = 3;
  localparam int unsigned D1N   = 6;
  localparam int unsigned D2Beg = 10;
  localparam int unsigned D2N   = 4;

  typedef struct packed {
    logic signed [25:0]     num;
    logic signed [DirW-1:0] dir;
    logic signed [DirW-1:0] dir_o;
    logic [15:0]            pos_o;
    logic                   mirror;
    logic [TexWW-1:0]       w;
    logic [24:0]            anum;
    logic [DirW-1:0]        adir;
    logic                   dir_zero;
    logic                   res_zero;
    logic                   sat;
    logic [DirW-1:0]        rem1;
    logic [23:0]            dvd1;
    logic [PosW-1:0]        q1;
    logic [PosW-1:0]        perp;
    logic [PosW-1:0]        rem2;
    logic [LhW-1:0]         q2;
    logic                   lh_sat;
    logic [15:0]            prod_hi;
    logic [15:0]            frac;
    logic [TexCW-1:0]       tx;
    logic [LhW-1:0]         lh;
    logic [RowW-1:0]        ds;
    logic [RowW-1:0]        de;
  } pipe_t;

  logic [PosW-1:0]  player_x_q, player_y_q;
  logic [TexWW-1:0] tex_w_q;
  logic [NSt-1:0]   vld_q;
  pipe_t            st_q [NSt];
  wire pipe_t       st_d [NSt];
  logic             adv;

  assign adv     = !vld_q[Last] || !stall_i;
  assign stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= '0;
      player_y_q <= '0;
      tex_w_q    <= 11'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PLAYER_X:  player_x_q <= cfg_data_i;
        REG_PLAYER_Y:  player_y_q <= cfg_data_i;
        REG_TEX_WIDTH: tex_w_q    <= cfg_data_i[TexWW-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: select axis, numerator, texture width clamp
  pipe_t st_d_0;
  always_comb begin
    pipe_t n;
    logic [7:0]      hit_cell;
    logic            off;
    logic [PosW-1:0] pos;
    n    = '0;
    hit_cell = wall_side_i ? cell_y_i : cell_x_i;
    off  = wall_side_i ? step_y_i[1] : step_x_i[1];
    pos  = wall_side_i ? player_y_q : player_x_q;
    n.num   = 26'({2'b0, hit_cell, 16'h0}) - 26'({2'b0, pos}) + (off ? 26'h10000 : 26'h0);
    n.dir   = wall_side_i ? ray_dir_y_i : ray_dir_x_i;
    n.dir_o = wall_side_i ? ray_dir_x_i : ray_dir_y_i;
    n.pos_o = wall_side_i ? player_x_q[15:0] : player_y_q[15:0];
    n.mirror = (!wall_side_i && !ray_dir_x_i[DirW-1] && (ray_dir_x_i != '0)) ||
               (wall_side_i && ray_dir_y_i[DirW-1]);
    if (tex_w_q == '0)         n.w = 11'd1;
    else if (tex_w_q > TexWMax) n.w = TexWMax;
    else                       n.w = tex_w_q;
    st_d_0 = n;
  end
  assign st_d[0] = st_d_0;

  // stage 1: magnitudes and sign cases
  pipe_t st_d_1;
  always_comb begin
    pipe_t n;
    logic [25:0] nn;
    logic [DirW-1:0] nd;
    n  = st_q[0];
    nn = -n.num;
    nd = -n.dir;
    n.anum     = n.num[25] ? nn[24:0] : n.num[24:0];
    n.adir     = n.dir[DirW-1] ? nd : n.dir;
    n.dir_zero = (n.dir == '0);
    n.res_zero = (n.num == '0) || (n.num[25] != n.dir[DirW-1]);
    st_d_1 = n;
  end
  assign st_d[1] = st_d_1;

  // stage 2: overflow check, divider setup
  pipe_t st_d_2;
  always_comb begin
    pipe_t n;
    n      = st_q[1];
    n.sat  = ({1'b0, n.anum} >= {n.adir, 8'h0});
    n.rem1 = {1'b0, n.anum[24:8]};
    n.dvd1 = {n.anum[7:0], 16'h0};
    n.q1   = '0;
    st_d_2 = n;
  end
  assign st_d[2] = st_d_2;

  // distance divider
  for (genvar g = 0; g < D1N; g++) begin : g_div1
    pipe_t           n;
    logic [DirW-1:0] rem;
    logic [PosW-1:0] q;
    rcw_div_stage #(.DW(DirW), .QW(PosW), .BITS(4)) u_div (
      .rem_i  (st_q[D1Beg+g-1].rem1),
      .div_i  (st_q[D1Beg+g-1].adir),
      .bits_i (st_q[D1Beg+g-1].dvd1[23:20]),
      .q_i    (st_q[D1Beg+g-1].q1),
      .rem_o  (rem),
      .q_o    (q)
    );
    always_comb begin
      n      = st_q[D1Beg+g-1];
      n.rem1 = rem;
      n.q1   = q;
      n.dvd1 = {n.dvd1[19:0], 4'h0};
    end
    assign st_d[D1Beg+g] = n;
  end

  // stage 9: final distance, height divider setup
  pipe_t st_d_9;
  always_comb begin
    pipe_t n;
    n = st_q[D1Beg+D1N-1];
    if (n.dir_zero)      n.perp = DistMax;
    else if (n.res_zero) n.perp = '0;
    else if (n.sat)      n.perp = DistMax;
    else                 n.perp = n.q1;
    n.lh_sat = (PosW'(SCREEN_HEIGHT) >= n.perp);
    n.rem2   = PosW'(SCREEN_HEIGHT);
    n.q2     = '0;
    st_d_9 = n;
  end
  assign st_d[9] = st_d_9;

  // height divider with texture path alongside
  for (genvar g = 0; g < D2N; g++) begin : g_div2
    pipe_t           n;
    logic [PosW-1:0] rem;
    logic [LhW-1:0]  q;
    rcw_div_stage #(.DW(PosW), .QW(LhW), .BITS(4)) u_div (
      .rem_i  (st_q[D2Beg+g-1].rem2),
      .div_i  (st_q[D2Beg+g-1].perp),
      .bits_i (4'h0),
      .q_i    (st_q[D2Beg+g-1].q2),
      .rem_o  (rem),
      .q_o    (q)
    );
    always_comb begin
      logic signed [24:0] a;
      logic signed [42:0] prod;
      logic [26:0]        tp;
      logic [TexWW-1:0]   mr;
      n    = st_q[D2Beg+g-1];
      a    = $signed({1'b0, n.perp});
      prod = '0;
      tp   = '0;
      mr   = '0;
      n.rem2 = rem;
      n.q2   = q;
      case (g)
        0: begin
          prod      = a * n.dir_o;
          n.prod_hi = prod[31:16];
        end
        1: n.frac = n.pos_o + n.prod_hi;
        2: begin
          tp   = n.frac * n.w;
          n.tx = tp[25:16];
        end
        3: begin
          mr = n.w - {1'b0, n.tx} - 11'd1;
          if (n.mirror) n.tx = mr[TexCW-1:0];
        end
        default: ;
      endcase
    end
    assign st_d[D2Beg+g] = n;
  end

  // last stage: height and clamped rows
  pipe_t st_d_l;
  always_comb begin
    pipe_t n;
    logic [SumW-1:0] half, lh2, s, e;
    n    = st_q[Last-1];
    n.lh = n.lh_sat ? HeightMax : n.q2;
    half = SumW'(SCREEN_HEIGHT / 2);
    lh2  = SumW'(n.lh[LhW-1:1]);
    s    = (lh2 >= half) ? '0 : half - lh2;
    e    = lh2 + half;
    if (e >= SumW'(SCREEN_HEIGHT)) e = SumW'(SCREEN_HEIGHT - 1);
    n.ds = s[RowW-1:0];
    n.de = e[RowW-1:0];
    st_d_l = n;
  end
  assign st_d[Last] = st_d_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSt-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NSt; k++) st_q[k] <= st_d[k];
    end
  end

  assign valid_o          = vld_q[Last];
  assign wall_distance_o  = st_q[Last].perp;
  assign slice_height_o   = st_q[Last].lh;
  assign row_first_o      = st_q[Last].ds;
  assign row_last_o       = st_q[Last].de;
  assign texture_column_o = st_q[Last].tx;

  `RCW_ASSERT_IMP(a_zero_dist_max_h, valid_o && (wall_distance_o == '0),
    slice_height_o == HeightMax, "zero distance without saturated height")
  `RCW_ASSERT_IMP(a_tex_in_range, valid_o,
    {1'b0, texture_column_o} < st_q[Last].w, "texture column beyond width")
  `RCW_ASSERT_NXT(a_hold_on_stall, !adv,
    $stable(vld_q), "pipeline moved while stalled")

endmodule

`default_nettype wire
